// ----- rtl/rita_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_pkg
// shared widths, constants, types and the digit-to-ascii mapping for the
// radix integer-to-ascii converter
// ----------------------------------------------------------------------------
package rita_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int IN_BITS            = 32;
    localparam int IN_TDATA_BITS      = ((IN_BITS + 7) / 8) * 8;
    localparam int RADIX_BITS         = 6;
    localparam int DIGIT_BITS         = 5;
    localparam int CHAR_BITS          = 7;
    localparam int OUT_TDATA_BITS     = ((CHAR_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_BITS          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(32);
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);

    localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT   = DIGIT_BITS'(10);
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0]  CHAR_LETTER_A = CHAR_BITS'(65);
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE     = '0;

    typedef struct packed {
        logic                  bad;
        logic [RADIX_BITS-1:0] radix;
    } rita_ctl_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d >= DIGIT_LIMIT)
        begin
            c = CHAR_LETTER_A + CHAR_BITS'(d) - CHAR_BITS'(DIGIT_LIMIT);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        return c;
    endfunction

endpackage

// ----- rtl/rita_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_front
// holds the radix register, accepts input beats and tags each job as valid
// or bad radix before it enters the job queue
// ----------------------------------------------------------------------------
module rita_front
    import rita_pkg::*;
#(
    parameter int VAL_W = VALUE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [RADIX_BITS-1:0]    cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [VAL_W-1:0]         q_value,
    output rita_ctl_t                q_ctl
);

    logic [RADIX_BITS-1:0] radix_reg;
    logic [RADIX_BITS-1:0] radix_next;

    always_comb
    begin
        radix_next = cfg_we ? cfg_wdata : radix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    always_comb
    begin
        s_axis_tready = !q_full;
        q_push        = s_axis_tvalid && !q_full;
        q_value       = s_axis_tdata[VAL_W-1:0];
        q_ctl.bad     = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
        q_ctl.radix   = radix_reg;
    end

endmodule

// ----- rtl/rita_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_fifo
// short job queue between the front and the conversion engine
// ----------------------------------------------------------------------------
module rita_fifo
    import rita_pkg::*;
#(
    parameter int DATA_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic [DATA_BITS-1:0] pop_data,
    output logic                 empty
);

    logic [DATA_BITS-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QCNT_BITS-1:0] cnt_next;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        full     = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
        empty    = (cnt_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/rita_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_back
// conversion engine: bit-serial division by the radix, one digit per pass,
// digits stacked and then sent most significant first through an output
// register
// ----------------------------------------------------------------------------
module rita_back
    import rita_pkg::*;
#(
    parameter int VAL_W = VALUE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  logic [VAL_W-1:0]          job_value,
    input  rita_ctl_t                 job_ctl,
    output logic                      job_pop,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser
);

    localparam int IW = (VAL_W > 1) ? $clog2(VAL_W) : 1;
    localparam int CW = $clog2(VAL_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_BAD  = 4'b1000
    } rita_state_t;

    rita_state_t           state_reg;
    rita_state_t           state_next;
    logic [VAL_W-1:0]      val_reg;
    logic [VAL_W-1:0]      val_next;
    logic [DIGIT_BITS-1:0] rem_reg;
    logic [DIGIT_BITS-1:0] rem_next;
    logic [RADIX_BITS-1:0] radix_reg;
    logic [RADIX_BITS-1:0] radix_next;
    logic [IW-1:0]         step_reg;
    logic [IW-1:0]         step_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         cnt_dec;
    logic [DIGIT_BITS-1:0] digit_reg [VAL_W];
    logic                  digit_we;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [CHAR_BITS-1:0]  m_char_reg;
    logic [CHAR_BITS-1:0]  m_char_next;
    logic                  m_last_reg;
    logic                  m_last_next;
    logic                  m_bad_reg;
    logic                  m_bad_next;

    logic [RADIX_BITS-1:0] trial;
    logic                  ge;
    logic [DIGIT_BITS-1:0] rem_step;
    logic [VAL_W-1:0]      val_step;
    logic                  out_free;

    always_comb
    begin
        trial    = {rem_reg, val_reg[VAL_W-1]};
        ge       = (trial >= radix_reg);
        rem_step = ge ? DIGIT_BITS'(trial - radix_reg) : trial[DIGIT_BITS-1:0];
        val_step = {val_reg[VAL_W-2:0], ge};
        cnt_dec  = cnt_reg - CW'(1);
        out_free = !m_valid_reg || m_axis_tready;

        state_next   = state_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        digit_we     = 1'b0;
        job_pop      = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_bad_next   = m_bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    radix_next = job_ctl.radix;
                    val_next   = job_value;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = job_ctl.bad ? ST_BAD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                val_next  = val_step;
                step_next = step_reg + 1'b1;
                if (step_reg == IW'(VAL_W - 1))
                begin
                    // one digit done: stack remainder, continue on quotient
                    digit_we  = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (val_step == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_char(digit_reg[cnt_dec[IW-1:0]]);
                    m_last_next  = (cnt_reg == CW'(1));
                    m_bad_next   = 1'b0;
                    cnt_next     = cnt_dec;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_NONE;
                    m_last_next  = 1'b1;
                    m_bad_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
        if (digit_we)
        begin
            digit_reg[cnt_reg[IW-1:0]] <= rem_step;
        end
    end

    always_comb
    begin
        m_axis_tvalid = m_valid_reg;
        m_axis_tdata  = OUT_TDATA_BITS'(m_char_reg);
        m_axis_tlast  = m_last_reg;
        m_axis_tuser  = m_bad_reg;
    end

endmodule

// ----- rtl/radix_integer_to_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// converts an unsigned integer into ascii digits in a configurable radix,
// most significant digit first, last digit marked with tlast
// ----------------------------------------------------------------------------
// channel   dir  tdata                    tlast        tuser
// s_axis    in   [31:0] value             -            -
// m_axis    out  [6:0] digit_char, [7] 0  last digit   bad_radix
// cfg       in   cfg_wdata[5:0] radix, written when cfg_we is high
//
// a value is taken from the queue when the engine is idle; each digit comes from
// one pass of the bit-serial divider over all W value bits (W = min(VALUE_BITS,
// 32)); digits then leave one per cycle while the output is not stalled. a bad
// radix job gives a lone last beat with zero data. reset clears control state and
// sets the radix to 10. a two-beat job queue takes input while the engine works;
// a stalled output holds in its register and stalls the engine, then the input.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii
    import rita_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [RADIX_BITS-1:0]     cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // [31:0] value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // [6:0] digit_char, [7] zero
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser   // [0] bad_radix
);

    localparam int VAL_W  = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
    localparam int CTL_W  = $bits(rita_ctl_t);
    localparam int JOB_W  = CTL_W + VAL_W;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic [VAL_W-1:0]  front_value;
    rita_ctl_t         front_ctl;
    logic [JOB_W-1:0]  q_in;
    logic [JOB_W-1:0]  q_out;
    logic [VAL_W-1:0]  job_value;
    rita_ctl_t         job_ctl;

    rita_front #(
        .VAL_W (VAL_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_value       (front_value),
        .q_ctl         (front_ctl)
    );

    assign q_in      = {front_ctl, front_value};
    assign job_value = q_out[VAL_W-1:0];
    assign job_ctl   = rita_ctl_t'(q_out[JOB_W-1:VAL_W]);

    rita_fifo #(
        .DATA_BITS (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    rita_back #(
        .VAL_W (VAL_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!q_empty),
        .job_value     (job_value),
        .job_ctl       (job_ctl),
        .job_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/rita_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_checker
// port-level checks on the output stream of the converter
// ----------------------------------------------------------------------------
module rita_checker
    import rita_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                      m_axis_tlast,
    input logic                      m_axis_tuser
);

    logic first_reg;

    // set at the start of each run of beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            first_reg <= m_axis_tlast;
        end
    end

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("bad radix beat must be a lone last beat with zero data");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            ((m_axis_tdata >= OUT_TDATA_BITS'(48)) && (m_axis_tdata <= OUT_TDATA_BITS'(57)))
         || ((m_axis_tdata >= OUT_TDATA_BITS'(65)) && (m_axis_tdata <= OUT_TDATA_BITS'(86))))
        else $error("digit beat outside 0-9 and A-V");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && first_reg && !m_axis_tlast |->
            (m_axis_tdata != OUT_TDATA_BITS'(48)))
        else $error("multi-digit run starts with a zero digit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
         && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind radix_integer_to_ascii rita_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
